// ----- hw/rtl/phx_pkg.sv -----
// ---------------------------------------------------------------------------
// phx_pkg: shared types and constants for the Philox4x32 generator
// Beat payloads, pipeline stage payload, key schedule and round helpers.
// ---------------------------------------------------------------------------
package phx_pkg;

   localparam logic [31:0] MULT_A = 32'hD2511F53;
   localparam logic [31:0] MULT_B = 32'hCD9E8D57;
   localparam logic [31:0] WEYL_A = 32'h9E3779B9;
   localparam logic [31:0] WEYL_B = 32'hBB67AE85;

   // register indexes
   localparam int unsigned REG_SEED = 0;

   typedef struct packed {
      logic [63:0] path_num;
      logic [31:0] draw_num;
      logic [31:0] stream_id;
   } req_type;

   typedef struct packed {
      logic [31:0] word0;
      logic [31:0] word1;
      logic [31:0] word2;
      logic [31:0] word3;
   } rsp_type;

   // products of one round plus the two words that pass through
   typedef struct packed {
      logic [63:0] pa;
      logic [63:0] pb;
      logic [31:0] c1;
      logic [31:0] c3;
   } mid_type;

   typedef struct packed {
      logic [31:0] c0;
      logic [31:0] c1;
      logic [31:0] c2;
      logic [31:0] c3;
   } ctr_type;

   // k1 in the upper half so the packed key lines up with the seed register
   typedef struct packed {
      logic [31:0] k1;
      logic [31:0] k0;
   } key_type;

   function automatic logic [63:0] mul32(input logic [31:0] a, input logic [31:0] b);
      logic [63:0] p;
      p = 64'(a) * 64'(b);
      return p;
   endfunction

   function automatic logic [31:0] weyl_off(input logic [31:0] base, input logic [4:0] rnd);
      logic [36:0] p;
      p = 37'(base) * 37'(rnd);
      return p[31:0];
   endfunction

   // key used by round rnd for a given seed
   function automatic key_type key_at(input logic [63:0] seed, input logic [4:0] rnd);
      key_type k;
      k.k0 = seed[31:0] + weyl_off(WEYL_A, rnd);
      k.k1 = seed[63:32] + weyl_off(WEYL_B, rnd);
      return k;
   endfunction

   // xor half of a round: finish the counter from the registered products
   function automatic ctr_type mix(input mid_type m, input key_type k);
      ctr_type c;
      c.c0 = m.pb[63:32] ^ m.c1 ^ k.k0;
      c.c1 = m.pb[31:0];
      c.c2 = m.pa[63:32] ^ m.c3 ^ k.k1;
      c.c3 = m.pa[31:0];
      return c;
   endfunction

endpackage

// ----- hw/rtl/phx_round.sv -----
// ---------------------------------------------------------------------------
// phx_round: one pipeline stage of the Philox round chain
// Finishes the previous round's xor mix, then registers the next round's
// two 32x32 products. Holds its beat when the stage below is full.
// ---------------------------------------------------------------------------
module phx_round (
   input  logic              clock,
   input  logic              reset,
   input  logic              up_valid,
   input  phx_pkg::mid_type  up_mid,
   input  phx_pkg::key_type  key,
   input  logic              dn_adv,
   output logic              adv,
   output logic              valid,
   output phx_pkg::mid_type  mid
);

   logic             valid_ff;
   logic             valid_in;
   phx_pkg::mid_type mid_ff;
   phx_pkg::mid_type mid_in;
   phx_pkg::ctr_type ctr;

   always_comb begin
      ctr       = phx_pkg::mix(up_mid, key);
      mid_in.pa = phx_pkg::mul32(phx_pkg::MULT_A, ctr.c0);
      mid_in.pb = phx_pkg::mul32(phx_pkg::MULT_B, ctr.c2);
      mid_in.c1 = ctr.c1;
      mid_in.c3 = ctr.c3;
   end

   // stage may load when empty or when its beat moves on
   assign adv      = !valid_ff || dn_adv;
   assign valid_in = adv ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mid_ff <= mid_in;
      end
   end

   assign valid = valid_ff;
   assign mid   = mid_ff;

endmodule

// ----- hw/rtl/philox_counter_rng_top.sv -----
// ---------------------------------------------------------------------------
// philox_counter_rng_top: Philox4x32 counter-based random generator
// Each request beat (path number, draw number, stream) forms the four-word
// counter; the 64-bit seed register is the key. Every request gives one
// response beat of four 32-bit words.
//   Channels: req_* in, rsp_* out, valid/stall handshake; csr_* APB-style
//   port holding the seed at byte address 0 (64-bit data).
//   Throughput: one beat per cycle while the response side does not stall; every stage has its own valid bit.
//   Pipeline: stage 0 takes the first round's products at the accept edge,
//   one more stage per later round, then the output register.
//   Key schedule: the per-round keys are recomputed on a seed write and kept
//   in registers; write the seed only while the pipeline is empty.
//   Reset: pipeline emptied, seed cleared to zero.
//   Stall: a stalled response holds; stages above fill up bubbles first,
//   and req_stall rises only when every stage holds a beat.
// ---------------------------------------------------------------------------
module philox_counter_rng_top #(
   parameter int unsigned ROUNDS = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  phx_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output phx_pkg::rsp_type  rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [63:0]       csr_pwdata,
   output logic [63:0]       csr_prdata,
   output logic              csr_pready
);

   localparam logic [2:0] SEED_ADDR = 3'(phx_pkg::REG_SEED * 8);

   logic [63:0]      seed_ff;
   logic             seed_wr;
   phx_pkg::key_type key_ff [ROUNDS];

   logic             stage_valid [ROUNDS];
   logic             stage_adv   [ROUNDS];
   logic             stage_dn    [ROUNDS];
   phx_pkg::mid_type stage_mid   [ROUNDS];

   logic             s0_valid_ff;
   logic             s0_valid_in;
   phx_pkg::mid_type s0_mid_ff;
   phx_pkg::mid_type s0_mid_in;

   logic             out_adv;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   phx_pkg::rsp_type rsp_data_ff;
   phx_pkg::rsp_type rsp_data_in;
   phx_pkg::ctr_type fin_ctr;

   // ---------------- configuration ----------------
   assign csr_pready = 1'b1;
   assign seed_wr    = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr == SEED_ADDR);
   assign csr_prdata = (csr_paddr == SEED_ADDR) ? seed_ff : 64'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= 64'd0;
      end else if (seed_wr) begin
         seed_ff <= csr_pwdata;
      end
   end

   for (genvar r = 0; r < ROUNDS; r++) begin : g_key
      always_ff @(posedge clock) begin
         if (reset) begin
            key_ff[r] <= phx_pkg::key_at(64'd0, 5'(r));
         end else if (seed_wr) begin
            key_ff[r] <= phx_pkg::key_at(csr_pwdata, 5'(r));
         end
      end
   end

   // ---------------- stage 0: first round products ----------------
   always_comb begin
      s0_mid_in.pa = phx_pkg::mul32(phx_pkg::MULT_A, req_data.path_num[31:0]);
      s0_mid_in.pb = phx_pkg::mul32(phx_pkg::MULT_B, req_data.draw_num);
      s0_mid_in.c1 = req_data.path_num[63:32];
      s0_mid_in.c3 = req_data.stream_id;
   end

   assign stage_adv[0]   = !s0_valid_ff || stage_dn[0];
   assign s0_valid_in    = stage_adv[0] ? req_valid : s0_valid_ff;
   assign stage_valid[0] = s0_valid_ff;
   assign stage_mid[0]   = s0_mid_ff;
   assign req_stall      = !stage_adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= s0_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_adv[0]) begin
         s0_mid_ff <= s0_mid_in;
      end
   end

   // ---------------- round chain ----------------
   for (genvar s = 0; s < ROUNDS; s++) begin : g_dn
      if (s == ROUNDS - 1) begin : g_last
         assign stage_dn[s] = out_adv;
      end else begin : g_mid
         assign stage_dn[s] = stage_adv[s + 1];
      end
   end

   for (genvar s = 1; s < ROUNDS; s++) begin : g_round
      phx_round u_round (
         .clock    (clock),
         .reset    (reset),
         .up_valid (stage_valid[s - 1]),
         .up_mid   (stage_mid[s - 1]),
         .key      (key_ff[s - 1]),
         .dn_adv   (stage_dn[s]),
         .adv      (stage_adv[s]),
         .valid    (stage_valid[s]),
         .mid      (stage_mid[s])
      );
   end

   // ---------------- output register: last xor mix ----------------
   always_comb begin
      fin_ctr           = phx_pkg::mix(stage_mid[ROUNDS - 1], key_ff[ROUNDS - 1]);
      rsp_data_in.word0 = fin_ctr.c0;
      rsp_data_in.word1 = fin_ctr.c1;
      rsp_data_in.word2 = fin_ctr.c2;
      rsp_data_in.word3 = fin_ctr.c3;
   end

   assign out_adv      = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = out_adv ? stage_valid[ROUNDS - 1] : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   // accepted request lands in stage 0
   a_req_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> s0_valid_ff)
      else $error("accepted request beat missing from stage 0");

   // a held stage 0 beat keeps its products
   a_s0_hold: assert property (@(posedge clock) disable iff (reset)
      s0_valid_ff && !stage_adv[0] |=> s0_valid_ff && $stable(s0_mid_ff))
      else $error("stage 0 beat lost or changed while held");

   // last stage beat moving out always reaches the response register
   a_out_load: assert property (@(posedge clock) disable iff (reset)
      stage_valid[ROUNDS - 1] && out_adv |=> rsp_valid_ff)
      else $error("last stage beat dropped at output");

   // first-round key always matches the seed register
   a_key0: assert property (@(posedge clock) disable iff (reset)
      key_ff[0] == seed_ff)
      else $error("round 0 key out of step with seed");
`endif

endmodule

// ----- verif/philox_counter_rng_top_test.sv -----
// ---------------------------------------------------------------------------
// philox_counter_rng_top_test: self-checking bench for the Philox4x32 block
// Request beats come from a pending queue through a clocked driver; a clocked
// monitor checks each response beat word by word against a local Philox4x32
// computation. The seed is rewritten between phases while the pipeline is
// empty, random bursts of idle and stall land on both channels, and one long
// response hold-off fills the pipeline so that the request side stalls.
// ---------------------------------------------------------------------------
module philox_counter_rng_top_test;

   localparam int unsigned ROUNDS = 10;
   localparam logic [2:0]  SEED_ADDR = 3'(phx_pkg::REG_SEED * 8);
   localparam int          LONG_HOLD = 80;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic             req_valid = 1'b0;
   logic             req_stall;
   phx_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   phx_pkg::rsp_type rsp_data;

   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [63:0] csr_pwdata = '0;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   phx_pkg::req_type pending_q[$];
   phx_pkg::rsp_type rng_words_q[$];
   logic [63:0]      seed_now = '0;

   int          errors = 0;
   int          beats_in = 0;
   int          beats_out = 0;
   int          seeds_used = 1;
   bit          no_idle = 1'b0;
   int          gap_left = 0;
   int          stall_left = 0;
   int          hold_requests = 0;
   int          holds_done = 0;

   philox_counter_rng_top #(.ROUNDS(ROUNDS)) uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Philox4x32 block for one counter under the given seed
   function automatic phx_pkg::rsp_type philox_block(input phx_pkg::req_type item,
                                                     input logic [63:0] key);
      logic [31:0]      c0, c1, c2, c3, k0, k1;
      logic [63:0]      pa, pb;
      phx_pkg::rsp_type r;
      c0 = item.path_num[31:0];
      c1 = item.path_num[63:32];
      c2 = item.draw_num;
      c3 = item.stream_id;
      k0 = key[31:0];
      k1 = key[63:32];
      for (int i = 0; i < ROUNDS; i++) begin
         pa = {32'b0, phx_pkg::MULT_A} * {32'b0, c0};
         pb = {32'b0, phx_pkg::MULT_B} * {32'b0, c2};
         c0 = pb[63:32] ^ c1 ^ k0;
         c1 = pb[31:0];
         c2 = pa[63:32] ^ c3 ^ k1;
         c3 = pa[31:0];
         k0 = k0 + phx_pkg::WEYL_A;
         k1 = k1 + phx_pkg::WEYL_B;
      end
      r.word0 = c0;
      r.word1 = c1;
      r.word2 = c2;
      r.word3 = c3;
      return r;
   endfunction

   function automatic logic [31:0] pick_word(input int kind);
      logic [31:0] w;
      case (kind)
         0: w = '0;
         1: w = '1;
         2: w = 32'($urandom_range(0, 255));
         3: w = 32'h1 << $urandom_range(0, 31);
         default: w = $urandom;
      endcase
      return w;
   endfunction

   function automatic phx_pkg::req_type pick_item();
      phx_pkg::req_type it;
      it.path_num = {pick_word($urandom_range(0, 6)), pick_word($urandom_range(0, 6))};
      it.draw_num = pick_word($urandom_range(0, 6));
      if ($urandom_range(0, 3) != 0)
         it.stream_id = 32'($urandom_range(0, 1));
      else
         it.stream_id = pick_word($urandom_range(0, 6));
      return it;
   endfunction

   task automatic push_item(input logic [63:0] path, input logic [31:0] draw,
                            input logic [31:0] stream);
      phx_pkg::req_type it;
      it.path_num  = path;
      it.draw_num  = draw;
      it.stream_id = stream;
      pending_q.push_back(it);
   endtask

   // mostly runs of consecutive draws on one path, the rest scattered beats
   task automatic queue_random(input int count);
      phx_pkg::req_type it;
      int               run;
      while (count > 0) begin
         it = pick_item();
         if ($urandom_range(0, 9) < 7) begin
            run = $urandom_range(2, 16);
            if ($urandom_range(0, 3) == 0)
               it.draw_num = 32'hFFFF_FFFF - 32'($urandom_range(0, 8));
            for (int i = 0; i < run && count > 0; i++) begin
               pending_q.push_back(it);
               it.draw_num = it.draw_num + 1;
               count--;
            end
         end else begin
            pending_q.push_back(it);
            count--;
         end
      end
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_q.size() != 0 || rng_words_q.size() != 0 || req_valid);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [63:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock);
      while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == SEED_ADDR) begin
         seed_now = data;
         seeds_used++;
      end
   endtask

   task automatic csr_check_seed();
      logic [63:0] got;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= SEED_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock);
      while (!csr_pready);
      got = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (got !== seed_now) begin
         $error("seed readback mismatch: expected %h, got %h", seed_now, got);
         errors++;
      end
   endtask

   task automatic check_word(input string name, input logic [31:0] exp_w,
                             input logic [31:0] act_w);
      if (act_w !== exp_w) begin
         $error("%s mismatch: expected %h, got %h", name, exp_w, act_w);
         errors++;
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            rng_words_q.push_back(philox_block(req_data, seed_now));
            beats_in++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 7) == 0) begin
               gap_left = $urandom_range(1, 12) - 1;
               req_valid <= 1'b0;
            end else if (pending_q.size() != 0) begin
               req_data  <= pending_q.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response stall: random bursts plus the requested long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (hold_requests != holds_done) begin
         holds_done++;
         stall_left = LONG_HOLD - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 12) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // response monitor
   always @(posedge clock) begin
      phx_pkg::rsp_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rng_words_q.size() == 0) begin
            $error("response beat with nothing outstanding: %h", rsp_data);
            errors++;
         end else begin
            exp_r = rng_words_q.pop_front();
            check_word("word0", exp_r.word0, rsp_data.word0);
            check_word("word1", exp_r.word1, rsp_data.word1);
            check_word("word2", exp_r.word2, rsp_data.word2);
            check_word("word3", exp_r.word3, rsp_data.word3);
            beats_out++;
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      csr_check_seed();

      // directed corners under the reset seed
      push_item(64'h0, 32'h0, 32'h0);
      push_item(64'h0, 32'h0, 32'h1);
      push_item('1, '1, '1);
      push_item('1, 32'h0, 32'h0);
      push_item(64'h0, '1, 32'h0);
      push_item(64'h0, 32'h0, '1);
      push_item(64'h0000_0000_FFFF_FFFF, 32'h0, 32'h1);
      push_item(64'hFFFF_FFFF_0000_0000, 32'h0, 32'h0);
      push_item(64'h8000_0000_0000_0000, 32'h8000_0000, 32'h8000_0000);
      push_item(64'h1, 32'h1, 32'h1);
      push_item(64'h0, 32'h0, 32'h2);
      push_item(64'h5555_5555_5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
      push_item(64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
      push_item(64'h0123_4567_89AB_CDEF, 32'hDEAD_BEEF, 32'h1);
      push_item(64'hFFFF_FFFF_FFFF_FFFE, 32'hFFFF_FFFF, 32'h0);
      push_item(64'h0, 32'hFFFF_FFFF, 32'h1);
      wait_idle();

      csr_write(SEED_ADDR, '1);
      csr_check_seed();
      push_item(64'h0, 32'h0, 32'h0);
      push_item('1, '1, '1);
      queue_random(100);
      wait_idle();

      csr_write(SEED_ADDR, 64'h0000_0000_FFFF_FFFF);
      queue_random(100);
      wait_idle();

      csr_write(SEED_ADDR, 64'hFFFF_FFFF_0000_0000);
      csr_check_seed();
      queue_random(100);
      wait_idle();

      // fill the pipeline against a long response hold-off
      csr_write(SEED_ADDR, {$urandom, $urandom});
      csr_check_seed();
      queue_random(120);
      hold_requests++;
      wait_idle();

      csr_write(SEED_ADDR, {$urandom, $urandom});
      queue_random(110);
      wait_idle();

      // last stretch at full rate with no idling on either side
      csr_write(SEED_ADDR, 64'h0);
      csr_check_seed();
      no_idle = 1'b1;
      push_item(64'h0, 32'h0, 32'h1);
      queue_random(100);
      wait_idle();

      repeat (ROUNDS + 5) @(posedge clock);
      if (rng_words_q.size() != 0) begin
         $error("%0d response beats never arrived", rng_words_q.size());
         errors++;
      end
      $display("tb: %0d request beats sent, %0d response beats checked", beats_in, beats_out);
      $display("tb: %0d seed settings incl. all-zero and all-one keys, one long hold-off",
               seeds_used);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("tb: failure");
      $finish;
   end

endmodule
